FILE: rtl/dpr_pkg.sv
// Shared types and constants for the delimited packet receiver.
`default_nettype none

package dpr_pkg;

	localparam int unsigned Depth     = 64;
	localparam int unsigned AddrW     = $clog2(Depth);
	localparam int unsigned PosW      = $clog2(Depth + 1);
	localparam int unsigned ByteW     = 8;
	localparam int unsigned IdxW      = 6;
	localparam int unsigned LenW      = 7;
	localparam int unsigned CmpW      = (PosW > IdxW) ? PosW : IdxW;
	localparam int unsigned ReqW      = 2;
	localparam int unsigned InDataW   = 16;
	localparam int unsigned OutFieldW = 1 + 1 + ByteW + LenW + 1;
	localparam int unsigned OutDataW  = 24;
	localparam int unsigned CfgIdxW   = 2;

	localparam logic [CfgIdxW-1:0] CFG_START = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_END1  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_END2  = 2'd2;

	typedef enum logic [ReqW-1:0] {
		REQ_BYTE = 2'd0,
		REQ_POLL = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'b001,
		PH_PAYLOAD  = 3'b010,
		PH_WAIT_END = 3'b100
	} phase_t;

	typedef struct packed {
		req_t             kind;
		logic [ByteW-1:0] data;
		logic [IdxW-1:0]  idx;
		logic             is_start;
		logic             is_end1;
		logic             is_end2;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} head_t;

endpackage

`default_nettype wire

FILE: rtl/dpr_front.sv
// Front end: accept request beats, classify them, and queue them for execution.
`default_nettype none

module dpr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [dpr_pkg::InDataW-1:0]   s_axis_tdata,
	input  wire logic [dpr_pkg::ReqW-1:0]      s_axis_tuser,
	input  wire logic [dpr_pkg::ByteW-1:0]     start_char,
	input  wire logic [dpr_pkg::ByteW-1:0]     first_end_char,
	input  wire logic [dpr_pkg::ByteW-1:0]     second_end_char,
	input  wire logic                          pop,
	output dpr_pkg::head_t                     head
);

	dpr_pkg::op_t     entry_q [2];
	dpr_pkg::op_t     op_in;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             do_pop;

	always_comb begin
		op_in.kind     = dpr_pkg::req_t'(s_axis_tuser);
		op_in.data     = s_axis_tdata[dpr_pkg::ByteW-1:0];
		op_in.idx      = s_axis_tdata[dpr_pkg::ByteW +: dpr_pkg::IdxW];
		op_in.is_start = (op_in.data == start_char);
		op_in.is_end1  = (op_in.data == first_end_char);
		op_in.is_end2  = (op_in.data == second_end_char);
	end

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign do_pop        = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dpr_back.sv
// Back end: packet parser state, payload store and registered result beat.
`default_nettype none

module dpr_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dpr_pkg::head_t               head,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [dpr_pkg::OutDataW-1:0]      m_axis_tdata
);

	dpr_pkg::phase_t              ph_q, ph_d;
	logic [dpr_pkg::PosW-1:0]     wp_q, wp_d;
	logic [dpr_pkg::PosW-1:0]     len_q, len_d;
	logic                         rdy_q, rdy_d;
	logic                         ovf_q, ovf_d;
	logic                         done_d, flag_d, rsel_d;
	logic                         mem_we, mem_re;
	logic                         issue;

	logic                         out_valid_s2;
	logic                         done_s2;
	logic                         flag_s2;
	logic                         rsel_s2;
	logic [dpr_pkg::PosW-1:0]     len_s2;
	logic                         ovf_s2;

	logic [dpr_pkg::ByteW-1:0]    mem [dpr_pkg::Depth];
	logic [dpr_pkg::ByteW-1:0]    rdata_q;
	logic [dpr_pkg::ByteW-1:0]    read_byte;

	assign issue = head.valid && (!out_valid_s2 || m_axis_tready);
	assign pop   = issue;

	always_comb begin
		ph_d   = ph_q;
		wp_d   = wp_q;
		len_d  = len_q;
		rdy_d  = rdy_q;
		ovf_d  = ovf_q;
		done_d = 1'b0;
		flag_d = 1'b0;
		rsel_d = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		unique case (head.op.kind)
			dpr_pkg::REQ_BYTE: begin
				unique case (ph_q)
					dpr_pkg::PH_PAYLOAD: begin
						if (head.op.is_end1) begin
							ph_d = dpr_pkg::PH_WAIT_END;
						end else if (wp_q < dpr_pkg::PosW'(dpr_pkg::Depth)) begin
							mem_we = issue;
							wp_d   = wp_q + dpr_pkg::PosW'(1);
						end else begin
							ovf_d = 1'b1;
						end
					end
					dpr_pkg::PH_WAIT_END: begin
						if (head.op.is_end2) begin
							ph_d   = dpr_pkg::PH_IDLE;
							len_d  = wp_q;
							rdy_d  = 1'b1;
							done_d = 1'b1;
						end
					end
					default: begin
						ph_d = dpr_pkg::PH_IDLE;
						if (head.op.is_start && !rdy_q) begin
							ph_d  = dpr_pkg::PH_PAYLOAD;
							wp_d  = '0;
							ovf_d = 1'b0;
						end
					end
				endcase
			end
			dpr_pkg::REQ_POLL: begin
				flag_d = rdy_q;
				rdy_d  = 1'b0;
			end
			dpr_pkg::REQ_READ: begin
				mem_re = issue;
				rsel_d = (dpr_pkg::CmpW'(head.op.idx) < dpr_pkg::CmpW'(len_q))
					&& (dpr_pkg::CmpW'(head.op.idx) < dpr_pkg::CmpW'(dpr_pkg::Depth));
			end
			default: begin
				rsel_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q[dpr_pkg::AddrW-1:0]] <= head.op.data;
		end
		if (mem_re) begin
			rdata_q <= mem[dpr_pkg::AddrW'(head.op.idx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q         <= dpr_pkg::PH_IDLE;
			wp_q         <= '0;
			len_q        <= '0;
			rdy_q        <= 1'b0;
			ovf_q        <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				ph_q         <= ph_d;
				wp_q         <= wp_d;
				len_q        <= len_d;
				rdy_q        <= rdy_d;
				ovf_q        <= ovf_d;
				out_valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			done_s2 <= done_d;
			flag_s2 <= flag_d;
			rsel_s2 <= rsel_d;
			len_s2  <= len_d;
			ovf_s2  <= ovf_d;
		end
	end

	assign read_byte     = rsel_s2 ? rdata_q : '0;
	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {
		(dpr_pkg::OutDataW - dpr_pkg::OutFieldW)'(0),
		ovf_s2,
		dpr_pkg::LenW'(len_s2),
		read_byte,
		flag_s2,
		done_s2
	};

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (wp_q == dpr_pkg::PosW'(dpr_pkg::Depth)))
		else $error("overflow flag set with store not full");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= dpr_pkg::PosW'(dpr_pkg::Depth)) && (wp_q <= dpr_pkg::PosW'(dpr_pkg::Depth)))
		else $error("length or write position beyond store depth");

	a_ready_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rdy_q) |-> (out_valid_s2 && done_s2))
		else $error("ready flag rose without a completion beat");

	a_no_issue_pending_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && done_s2) |-> rdy_q)
		else $error("completion beat pending but ready flag clear");

endmodule

`default_nettype wire

FILE: rtl/delimited_packet_receiver.sv
// Path: request beats pass a two-entry queue; result beats are registered.
// Throughput: one request beat per cycle while not stalled; a two-entry queue
// and an output register let the input and output sides stall independently.
// Reset: asynchronous, active low; parser state, flags and queue clear, delimiter
// registers return to '@', CR, LF; the payload store is not cleared.
`default_nettype none

module delimited_packet_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// rx_byte [7:0], read_index [13:8], zero [15:14]
	input  wire logic [dpr_pkg::InDataW-1:0]   s_axis_tdata,
	// req_type [1:0]
	input  wire logic [dpr_pkg::ReqW-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// packet_done [0], flag_value [1], read_byte [9:2], packet_length [16:10],
	// overflow [17], zero [23:18]
	output logic [dpr_pkg::OutDataW-1:0]       m_axis_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [dpr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [dpr_pkg::ByteW-1:0]     cfg_wdata
);

	logic [dpr_pkg::ByteW-1:0] start_char_q;
	logic [dpr_pkg::ByteW-1:0] first_end_q;
	logic [dpr_pkg::ByteW-1:0] second_end_q;
	dpr_pkg::head_t            head;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= 8'd64;
			first_end_q  <= 8'd13;
			second_end_q <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpr_pkg::CFG_START: start_char_q <= cfg_wdata;
				dpr_pkg::CFG_END1:  first_end_q  <= cfg_wdata;
				dpr_pkg::CFG_END2:  second_end_q <= cfg_wdata;
				default: begin
					start_char_q <= start_char_q;
				end
			endcase
		end
	end

	dpr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.start_char      (start_char_q),
		.first_end_char  (first_end_q),
		.second_end_char (second_end_q),
		.pop             (pop),
		.head            (head)
	);

	dpr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the delimited packet receiver: stream driver, result checker and stimulus.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [dpr_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;
	localparam logic [dpr_pkg::ByteW-1:0] DEF_START = 8'h40;
	localparam logic [dpr_pkg::ByteW-1:0] DEF_END1 = 8'h0D;
	localparam logic [dpr_pkg::ByteW-1:0] DEF_END2 = 8'h0A;

	typedef struct packed {
		logic                      ovf;
		logic [dpr_pkg::LenW-1:0]  len;
		logic [dpr_pkg::ByteW-1:0] rbyte;
		logic                      flag;
		logic                      done;
	} deframe_result_t;

	class deframer_board;
		logic [dpr_pkg::ByteW-1:0] start_ch = DEF_START;
		logic [dpr_pkg::ByteW-1:0] end1_ch = DEF_END1;
		logic [dpr_pkg::ByteW-1:0] end2_ch = DEF_END2;
		dpr_pkg::phase_t phase = dpr_pkg::PH_IDLE;
		logic [dpr_pkg::PosW-1:0] fill = '0;
		logic [dpr_pkg::LenW-1:0] done_len = '0;
		bit pending = 1'b0;
		bit ovf = 1'b0;
		logic [dpr_pkg::ByteW-1:0] store [dpr_pkg::Depth];
		deframe_result_t due_results [$];
		int errors = 0;

		function void set_delim(logic [dpr_pkg::CfgIdxW-1:0] idx,
				logic [dpr_pkg::ByteW-1:0] v);
			case (idx)
				dpr_pkg::CFG_START: start_ch = v;
				dpr_pkg::CFG_END1: end1_ch = v;
				dpr_pkg::CFG_END2: end2_ch = v;
				default: ;
			endcase
		endfunction

		function void note_request(dpr_pkg::req_t kind, logic [dpr_pkg::ByteW-1:0] b,
				logic [dpr_pkg::IdxW-1:0] ix);
			deframe_result_t want;
			want = '0;
			case (kind)
				dpr_pkg::REQ_BYTE: begin
					case (phase)
						dpr_pkg::PH_PAYLOAD: begin
							if (b == end1_ch) begin
								phase = dpr_pkg::PH_WAIT_END;
							end else if (fill < dpr_pkg::Depth) begin
								store[fill[dpr_pkg::AddrW-1:0]] = b;
								fill++;
							end else begin
								ovf = 1'b1;
							end
						end
						dpr_pkg::PH_WAIT_END: begin
							if (b == end2_ch) begin
								phase = dpr_pkg::PH_IDLE;
								done_len = fill;
								pending = 1'b1;
								want.done = 1'b1;
							end
						end
						default: begin
							phase = dpr_pkg::PH_IDLE;
							if (b == start_ch && !pending) begin
								phase = dpr_pkg::PH_PAYLOAD;
								fill = '0;
								ovf = 1'b0;
							end
						end
					endcase
				end
				dpr_pkg::REQ_POLL: begin
					want.flag = pending;
					pending = 1'b0;
				end
				dpr_pkg::REQ_READ: begin
					if (ix < done_len)
						want.rbyte = store[ix];
				end
				default: ;
			endcase
			want.len = done_len;
			want.ovf = ovf;
			due_results.push_back(want);
		endfunction

		function void report_field(string name, logic [dpr_pkg::ByteW-1:0] exp_v,
				logic [dpr_pkg::ByteW-1:0] act_v);
			errors++;
			if (errors <= 10)
				$display("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
		endfunction

		function void check_response(logic [dpr_pkg::OutDataW-1:0] word);
			deframe_result_t got;
			deframe_result_t want;
			got = word[dpr_pkg::OutFieldW-1:0];
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %h with nothing outstanding", word);
				return;
			end
			want = due_results.pop_front();
			if (got.done !== want.done)
				report_field("packet_done", dpr_pkg::ByteW'(want.done),
					dpr_pkg::ByteW'(got.done));
			if (got.flag !== want.flag)
				report_field("flag_value", dpr_pkg::ByteW'(want.flag),
					dpr_pkg::ByteW'(got.flag));
			if (got.rbyte !== want.rbyte)
				report_field("read_byte", want.rbyte, got.rbyte);
			if (got.len !== want.len)
				report_field("packet_length", dpr_pkg::ByteW'(want.len),
					dpr_pkg::ByteW'(got.len));
			if (got.ovf !== want.ovf)
				report_field("overflow", dpr_pkg::ByteW'(want.ovf),
					dpr_pkg::ByteW'(got.ovf));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// rx_byte [7:0], read_index [13:8], zero [15:14]
	logic [dpr_pkg::InDataW-1:0] s_axis_tdata = '0;
	// req_type [1:0]
	logic [dpr_pkg::ReqW-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// packet_done [0], flag_value [1], read_byte [9:2], packet_length [16:10],
	// overflow [17], zero [23:18]
	logic [dpr_pkg::OutDataW-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [dpr_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [dpr_pkg::ByteW-1:0] cfg_wdata = '0;

	deframer_board board = new();
	int beats_in = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit held_off = 1'b0;

	delimited_packet_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_response(m_axis_tdata);
	end

	// hold off once for a long stretch so the input side backs up
	initial begin
		wait (arst_n);
		forever begin
			if (!held_off && beats_in >= 120) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_item(input dpr_pkg::req_t kind, input logic [dpr_pkg::ByteW-1:0] b,
			input logic [dpr_pkg::IdxW-1:0] ix);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(dpr_pkg::InDataW - dpr_pkg::ByteW - dpr_pkg::IdxW){1'b0}}, ix, b};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_request(kind, b, ix);
		beats_in++;
	endtask

	task automatic send_byte(input logic [dpr_pkg::ByteW-1:0] b);
		send_item(dpr_pkg::REQ_BYTE, b, dpr_pkg::IdxW'($urandom_range(0, 63)));
	endtask

	task automatic send_read(input logic [dpr_pkg::IdxW-1:0] ix);
		send_item(dpr_pkg::REQ_READ, dpr_pkg::ByteW'($urandom_range(0, 255)), ix);
	endtask

	task automatic send_poll();
		send_item(dpr_pkg::REQ_POLL, dpr_pkg::ByteW'($urandom_range(0, 255)),
			dpr_pkg::IdxW'($urandom_range(0, 63)));
	endtask

	function automatic logic [dpr_pkg::ByteW-1:0] pick_other(
			logic [dpr_pkg::ByteW-1:0] avoid);
		logic [dpr_pkg::ByteW-1:0] b;
		do b = dpr_pkg::ByteW'($urandom_range(0, 255)); while (b == avoid);
		return b;
	endfunction

	task automatic send_random_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
			send_byte(board.start_ch);
			repeat (n) begin
				if ($urandom_range(0, 15) == 0)
					send_read(dpr_pkg::IdxW'($urandom_range(0, 63)));
				send_byte(pick_other(board.end1_ch));
			end
			send_byte(board.end1_ch);
			repeat ($urandom_range(0, 2)) send_byte(pick_other(board.end2_ch));
			send_byte(board.end2_ch);
			repeat ($urandom_range(0, 4))
				send_read(dpr_pkg::IdxW'($urandom_range(0, (n + 2 > 63) ? 63 : n + 2)));
			if ($urandom_range(0, 4) != 0)
				send_poll();
		end else if (pick < 85) begin
			send_byte(board.start_ch);
			repeat ($urandom_range(0, 5)) send_byte(dpr_pkg::ByteW'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 1)
				send_byte(board.end1_ch);
		end else begin
			repeat ($urandom_range(1, 6))
				send_item(dpr_pkg::req_t'($urandom_range(0, 3)),
					dpr_pkg::ByteW'($urandom_range(0, 255)),
					dpr_pkg::IdxW'($urandom_range(0, 63)));
		end
	endtask

	task automatic run_until(input int target);
		while (beats_in < target) send_random_sequence();
	endtask

	task automatic reconfigure(input logic [dpr_pkg::ByteW-1:0] st,
			input logic [dpr_pkg::ByteW-1:0] e1, input logic [dpr_pkg::ByteW-1:0] e2);
		logic [dpr_pkg::CfgIdxW-1:0] regs [4];
		logic [dpr_pkg::ByteW-1:0] vals [4];
		regs = '{dpr_pkg::CFG_START, dpr_pkg::CFG_END1, dpr_pkg::CFG_END2, CFG_SPARE};
		vals = '{st, e1, e2, pick_other(st)};
		s_axis_tvalid <= 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
			board.set_delim(regs[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [dpr_pkg::ByteW-1:0] tail;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_poll();
		send_read(0);
		send_item(dpr_pkg::REQ_NONE, 8'hFF, 6'h3F);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(DEF_START);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(DEF_START);
		send_read(0);
		send_byte(DEF_END1);
		send_byte(8'h55);
		send_byte(DEF_END1);
		send_byte(DEF_END2);
		send_byte(DEF_START);
		send_byte(DEF_END2);
		send_read(0);
		send_read(2);
		send_read(3);
		send_read(63);
		send_poll();
		send_poll();
		send_item(dpr_pkg::REQ_NONE, 8'h00, 6'h00);

		run_until(230);
		reconfigure(8'h00, 8'hFF, 8'h00);
		run_until(420);
		reconfigure(8'hFF, 8'h00, 8'hFF);
		run_until(610);
		tail = dpr_pkg::ByteW'($urandom_range(0, 255));
		reconfigure(pick_other(tail), tail, tail);
		run_until(790);
		reconfigure(DEF_START, DEF_END1, DEF_END2);
		calm = 1'b1;
		run_until(950);

		s_axis_tvalid <= 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (board.errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
